### rtl/vector_angle_to_clock_position_macros.svh
// ----------------------------------------------------------------------------
// vector_angle_to_clock_position_macros.svh
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef VECTOR_ANGLE_TO_CLOCK_POSITION_MACROS_SVH
`define VECTOR_ANGLE_TO_CLOCK_POSITION_MACROS_SVH

// same-cycle implication, quiet during reset
`define VAPOS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define VAPOS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define VAPOS_ASSERT_ALWAYS_NXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/vapos_pkg.sv
// ----------------------------------------------------------------------------
// vapos_pkg
// types, constants and the arctangent table of the clock position block
// ----------------------------------------------------------------------------
package vapos_pkg;

  localparam int SCALE_BITS   = 48;  // coordinates are scaled up to this many bits
  localparam int DATA_WIDTH   = 52;  // cordic x/y datapath, magnitudes stay below 2^50
  localparam int ANGLE_WIDTH  = 32;  // angle in fractions of a turn
  localparam int ATAN_ENTRIES = 24;
  localparam int STEP_WIDTH   = 8;
  localparam int NUM_LANES    = 3;

  localparam int LANE_HOUR   = 0;
  localparam int LANE_MINUTE = 1;
  localparam int LANE_SECOND = 2;

  localparam logic [ANGLE_WIDTH-1:0] HALF_TURN = 32'h8000_0000;

  localparam int HOUR_POS_WIDTH   = 4;
  localparam int MINUTE_POS_WIDTH = 6;

  typedef struct packed {
    logic                   zero;
    logic [ANGLE_WIDTH-1:0] phase;
  } vapos_lane_t;

  // atan(2^-i) in fractions of a turn, rounded
  function automatic logic [ANGLE_WIDTH-1:0] atan_entry(input int i);
    logic [ANGLE_WIDTH-1:0] v;
    case (i)
      0:       v = 32'd536870912;
      1:       v = 32'd316933406;
      2:       v = 32'd167458907;
      3:       v = 32'd85004756;
      4:       v = 32'd42667331;
      5:       v = 32'd21354465;
      6:       v = 32'd10679838;
      7:       v = 32'd5340245;
      8:       v = 32'd2670163;
      9:       v = 32'd1335087;
      10:      v = 32'd667544;
      11:      v = 32'd333772;
      12:      v = 32'd166886;
      13:      v = 32'd83443;
      14:      v = 32'd41722;
      15:      v = 32'd20861;
      16:      v = 32'd10430;
      17:      v = 32'd5215;
      18:      v = 32'd2608;
      19:      v = 32'd1304;
      20:      v = 32'd652;
      21:      v = 32'd326;
      22:      v = 32'd163;
      23:      v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/vapos_if.sv
// ----------------------------------------------------------------------------
// vapos_in_if / vapos_out_if
// valid/ready channels for hand vectors and clock positions
// ----------------------------------------------------------------------------
interface vapos_in_if #(
  parameter int CoordWidth = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] hour_y;
  logic signed [CoordWidth-1:0] hour_z;
  logic signed [CoordWidth-1:0] minute_y;
  logic signed [CoordWidth-1:0] minute_z;
  logic signed [CoordWidth-1:0] second_y;
  logic signed [CoordWidth-1:0] second_z;

  modport source (
    output valid, hour_y, hour_z, minute_y, minute_z, second_y, second_z,
    input  ready
  );
  modport sink (
    input  valid, hour_y, hour_z, minute_y, minute_z, second_y, second_z,
    output ready
  );
endinterface

interface vapos_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] hour_pos;
  logic [5:0] minute_pos;
  logic [5:0] second_pos;

  modport source (
    output valid, hour_pos, minute_pos, second_pos,
    input  ready
  );
  modport sink (
    input  valid, hour_pos, minute_pos, second_pos,
    output ready
  );
endinterface

### rtl/vector_angle_to_clock_position.sv
// ----------------------------------------------------------------------------
// vector_angle_to_clock_position
// hour, minute and second dial positions from three hand vectors
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  in       in   valid/ready   hour_y/z, minute_y/z, second_y/z
//  out      out  valid/ready   hour_pos, minute_pos, second_pos
//
//  one item per cycle while the output is not stalled; the pipeline has
//  one stage for the half-turn fold, one per cordic iteration (iterations
//  capped at 24) and one for the step scaling in the merge stage
//  reset clears the stage valid bits and the output item
//  a stalled output item freezes the whole pipeline; ready follows
//  whether the output register is free or being taken
// ----------------------------------------------------------------------------
module vector_angle_to_clock_position #(
  parameter int COORD_WIDTH      = 16,
  parameter int ANGLE_ITERATIONS = 16,
  parameter int HOUR_STEPS       = 12,
  parameter int MINUTE_STEPS     = 60
) (
  input  logic        clk,
  input  logic        rst,
  vapos_in_if.sink    in,
  vapos_out_if.source out
);
  import vapos_pkg::*;

  localparam int NIter = (ANGLE_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : ANGLE_ITERATIONS;

  logic                          advance;
  logic [NIter:0]                vld;
  vapos_lane_t [NUM_LANES-1:0]   lanes;

  assign in.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NIter-1:0], in.valid};
    end
  end

  vapos_lane #(.CoordWidth(COORD_WIDTH), .Iterations(NIter)) u_lane_hour (
    .clk (clk),
    .en  (advance),
    .y   (in.hour_y),
    .z   (in.hour_z),
    .res (lanes[LANE_HOUR])
  );

  vapos_lane #(.CoordWidth(COORD_WIDTH), .Iterations(NIter)) u_lane_minute (
    .clk (clk),
    .en  (advance),
    .y   (in.minute_y),
    .z   (in.minute_z),
    .res (lanes[LANE_MINUTE])
  );

  vapos_lane #(.CoordWidth(COORD_WIDTH), .Iterations(NIter)) u_lane_second (
    .clk (clk),
    .en  (advance),
    .y   (in.second_y),
    .z   (in.second_z),
    .res (lanes[LANE_SECOND])
  );

  vapos_merge #(.HourSteps(HOUR_STEPS), .MinuteSteps(MINUTE_STEPS)) u_merge (
    .clk        (clk),
    .rst        (rst),
    .last_valid (vld[NIter]),
    .lanes      (lanes),
    .advance    (advance),
    .out        (out)
  );

endmodule

### rtl/vapos_lane.sv
// ----------------------------------------------------------------------------
// vapos_lane
// pipelined cordic in vectoring mode, one stage per iteration
// ----------------------------------------------------------------------------
module vapos_lane #(
  parameter int CoordWidth = 16,
  parameter int Iterations = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [CoordWidth-1:0] y,
  input  logic signed [CoordWidth-1:0] z,
  output vapos_pkg::vapos_lane_t       res
);
  import vapos_pkg::*;

  localparam int Guard = SCALE_BITS - CoordWidth;

  logic signed [DATA_WIDTH-1:0]  ys;
  logic signed [DATA_WIDTH-1:0]  zs;
  logic signed [DATA_WIDTH-1:0]  cx [0:Iterations];
  logic signed [DATA_WIDTH-1:0]  cy [0:Iterations];
  logic        [ANGLE_WIDTH-1:0] ph [0:Iterations];
  logic                          zf [0:Iterations];

  assign ys = DATA_WIDTH'(y) <<< Guard;
  assign zs = DATA_WIDTH'(z) <<< Guard;

  // left half plane is turned by half a turn first
  always_ff @(posedge clk) begin
    if (en) begin
      if (zs[DATA_WIDTH-1]) begin
        cx[0] <= -zs;
        cy[0] <= -ys;
        ph[0] <= HALF_TURN;
      end else begin
        cx[0] <= zs;
        cy[0] <= ys;
        ph[0] <= '0;
      end
      zf[0] <= (y == '0) && (z == '0);
    end
  end

  for (genvar i = 0; i < Iterations; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[i][DATA_WIDTH-1]) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          ph[i+1] <= ph[i] + atan_entry(i);
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          ph[i+1] <= ph[i] - atan_entry(i);
        end
        zf[i+1] <= zf[i];
      end
    end
  end

  assign res.zero  = zf[Iterations];
  assign res.phase = ph[Iterations];

endmodule

### rtl/vapos_merge.sv
// ----------------------------------------------------------------------------
// vapos_merge
// scales the three lane angles to dial steps and holds the output item
// ----------------------------------------------------------------------------
module vapos_merge #(
  parameter int HourSteps   = 12,
  parameter int MinuteSteps = 60
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        last_valid,
  input  vapos_pkg::vapos_lane_t [vapos_pkg::NUM_LANES-1:0] lanes,
  output logic                                        advance,
  vapos_out_if.source                                 out
);
  import vapos_pkg::*;

  localparam int ProdWidth = ANGLE_WIDTH + STEP_WIDTH;

  localparam logic [STEP_WIDTH-1:0] Steps [NUM_LANES] = '{
    STEP_WIDTH'(HourSteps), STEP_WIDTH'(MinuteSteps), STEP_WIDTH'(MinuteSteps)
  };

  logic                  out_valid;
  logic [STEP_WIDTH-1:0] pos [NUM_LANES];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_scale
    logic [ANGLE_WIDTH-1:0] angle;
    logic [ProdWidth-1:0]   rounded;

    // dial angle runs clockwise from the top
    assign angle   = ANGLE_WIDTH'(0) - lanes[l].phase;
    assign rounded = ProdWidth'(angle) * ProdWidth'(Steps[l]) + ProdWidth'(HALF_TURN);
    assign pos[l]  = lanes[l].zero ? '0 : rounded[ProdWidth-1:ANGLE_WIDTH];
  end

  assign advance   = !out_valid || out.ready;
  assign out.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out.hour_pos   <= pos[LANE_HOUR][HOUR_POS_WIDTH-1:0];
      out.minute_pos <= pos[LANE_MINUTE][MINUTE_POS_WIDTH-1:0];
      out.second_pos <= pos[LANE_SECOND][MINUTE_POS_WIDTH-1:0];
    end
  end

endmodule

### rtl/vapos_checker.sv
// ----------------------------------------------------------------------------
// vapos_checker
// port-level checks on the clock position block
// ----------------------------------------------------------------------------
`include "vector_angle_to_clock_position_macros.svh"

module vapos_checker #(
  parameter int HourSteps   = 12,
  parameter int MinuteSteps = 60
) (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] hour_pos,
  input logic [5:0] minute_pos,
  input logic [5:0] second_pos
);

  // a waiting output item keeps its fields
  `VAPOS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(hour_pos) && $stable(minute_pos) && $stable(second_pos),
    "output item changed while stalled")

  // an empty output register never holds back an input item
  `VAPOS_ASSERT_IMP(a_ready_when_empty, clk, rst, !out_valid, in_ready,
    "input stalled with output register empty")

  // positions never pass the step count
  `VAPOS_ASSERT_IMP(a_pos_range, clk, rst, out_valid,
    ((HourSteps > 15) || (hour_pos <= HourSteps)) &&
    ((MinuteSteps > 63) || ((minute_pos <= MinuteSteps) && (second_pos <= MinuteSteps))),
    "position beyond step count")

  // reset empties the output
  `VAPOS_ASSERT_ALWAYS_NXT(a_reset_empty, clk, rst, !out_valid,
    "output item present after reset")

endmodule

bind vector_angle_to_clock_position vapos_checker #(
  .HourSteps   (HOUR_STEPS),
  .MinuteSteps (MINUTE_STEPS)
) u_vapos_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in.ready),
  .out_valid  (out.valid),
  .out_ready  (out.ready),
  .hour_pos   (out.hour_pos),
  .minute_pos (out.minute_pos),
  .second_pos (out.second_pos)
);
